[design/fpcu_pkg.sv]
// Shared types, codes and constants of the fixed-point calculator unit.
package fpcu_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ROOT_ITER = 8;

    localparam logic [2:0] FUNC_ADD  = 3'd0;
    localparam logic [2:0] FUNC_SUB  = 3'd1;
    localparam logic [2:0] FUNC_MUL  = 3'd2;
    localparam logic [2:0] FUNC_DIV  = 3'd3;
    localparam logic [2:0] FUNC_POW  = 3'd4;
    localparam logic [2:0] FUNC_ROOT = 3'd5;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_DIV0     = 3'd1;
    localparam logic [2:0] STAT_NEG_ROOT = 3'd2;
    localparam logic [2:0] STAT_SAT      = 3'd3;
    localparam logic [2:0] STAT_INVALID  = 3'd4;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_fpcu_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [2:0]               status;
    } t_fpcu_out;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_MUL_PACK, S_DIV_STEP, S_DIV_PACK,
        S_POW_MUL, S_POW_UPD, S_POW_PACK, S_ROOT_LEN, S_ROOT_NORM,
        S_ROOT_M1, S_ROOT_M2, S_ROOT_M3, S_ROOT_B, S_ROOT_PACK, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_LOAD, CMD_ADD, CMD_MUL, CMD_MUL_PACK,
        CMD_DIV_INIT, CMD_DIV_STEP, CMD_DIV_PACK,
        CMD_POW_INIT, CMD_POW_MUL, CMD_POW_UPD, CMD_POW_PACK,
        CMD_ROOT_INIT, CMD_ROOT_LEN, CMD_ROOT_NORM, CMD_ROOT_M1,
        CMD_ROOT_M2, CMD_ROOT_M3, CMD_ROOT_B, CMD_ROOT_PACK,
        CMD_ZERO, CMD_ONE, CMD_ERR
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] err;
    } t_ctrl;

    typedef struct packed {
        logic [2:0] func;
        logic       na;
        logic       nb;
        logic       a_zero;
        logic       b_zero;
        logic       div_last;
        logic       pow_stop;
        logic       len_done;
        logic       root_stop;
    } t_stat;

endpackage

[design/fpcu_ctrl.sv]
// Controller state machine that sequences the calculator datapath.
module fpcu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fpcu_pkg::t_stat i_stat,
    output fpcu_pkg::t_ctrl o_ctrl,
    output logic            o_busy,
    output logic            o_valid
);

    fpcu_pkg::t_state r_state;
    fpcu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpcu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpcu_pkg::S_IDLE: begin
                if (i_start) n_state = fpcu_pkg::S_DISPATCH;
            end
            fpcu_pkg::S_DISPATCH: begin
                case (i_stat.func)
                    fpcu_pkg::FUNC_MUL: n_state = fpcu_pkg::S_MUL_PACK;
                    fpcu_pkg::FUNC_DIV: begin
                        n_state = i_stat.b_zero ? fpcu_pkg::S_DONE : fpcu_pkg::S_DIV_STEP;
                    end
                    fpcu_pkg::FUNC_POW: begin
                        if (i_stat.a_zero || i_stat.nb || i_stat.b_zero) begin
                            n_state = fpcu_pkg::S_DONE;
                        end else begin
                            n_state = fpcu_pkg::S_POW_MUL;
                        end
                    end
                    fpcu_pkg::FUNC_ROOT: begin
                        if (i_stat.na || i_stat.a_zero) begin
                            n_state = fpcu_pkg::S_DONE;
                        end else begin
                            n_state = fpcu_pkg::S_ROOT_LEN;
                        end
                    end
                    default: n_state = fpcu_pkg::S_DONE;
                endcase
            end
            fpcu_pkg::S_MUL_PACK: n_state = fpcu_pkg::S_DONE;
            fpcu_pkg::S_DIV_STEP: begin
                if (i_stat.div_last) n_state = fpcu_pkg::S_DIV_PACK;
            end
            fpcu_pkg::S_DIV_PACK: n_state = fpcu_pkg::S_DONE;
            fpcu_pkg::S_POW_MUL:  n_state = fpcu_pkg::S_POW_UPD;
            fpcu_pkg::S_POW_UPD: begin
                n_state = i_stat.pow_stop ? fpcu_pkg::S_POW_PACK : fpcu_pkg::S_POW_MUL;
            end
            fpcu_pkg::S_POW_PACK: n_state = fpcu_pkg::S_DONE;
            fpcu_pkg::S_ROOT_LEN: begin
                if (i_stat.len_done) n_state = fpcu_pkg::S_ROOT_NORM;
            end
            fpcu_pkg::S_ROOT_NORM: n_state = fpcu_pkg::S_ROOT_M1;
            fpcu_pkg::S_ROOT_M1:   n_state = fpcu_pkg::S_ROOT_M2;
            fpcu_pkg::S_ROOT_M2:   n_state = fpcu_pkg::S_ROOT_M3;
            fpcu_pkg::S_ROOT_M3:   n_state = fpcu_pkg::S_ROOT_B;
            fpcu_pkg::S_ROOT_B: begin
                n_state = i_stat.root_stop ? fpcu_pkg::S_ROOT_PACK : fpcu_pkg::S_ROOT_M1;
            end
            fpcu_pkg::S_ROOT_PACK: n_state = fpcu_pkg::S_DONE;
            fpcu_pkg::S_DONE:      n_state = fpcu_pkg::S_IDLE;
            default:               n_state = fpcu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.cmd = fpcu_pkg::CMD_NOP;
        o_ctrl.err = fpcu_pkg::STAT_OK;
        o_busy     = (r_state != fpcu_pkg::S_IDLE);
        o_valid    = (r_state == fpcu_pkg::S_DONE);
        case (r_state)
            fpcu_pkg::S_IDLE: begin
                if (i_start) o_ctrl.cmd = fpcu_pkg::CMD_LOAD;
            end
            fpcu_pkg::S_DISPATCH: begin
                case (i_stat.func)
                    fpcu_pkg::FUNC_ADD: o_ctrl.cmd = fpcu_pkg::CMD_ADD;
                    fpcu_pkg::FUNC_SUB: o_ctrl.cmd = fpcu_pkg::CMD_ADD;
                    fpcu_pkg::FUNC_MUL: o_ctrl.cmd = fpcu_pkg::CMD_MUL;
                    fpcu_pkg::FUNC_DIV: begin
                        if (i_stat.b_zero) begin
                            o_ctrl.cmd = fpcu_pkg::CMD_ERR;
                            o_ctrl.err = fpcu_pkg::STAT_DIV0;
                        end else begin
                            o_ctrl.cmd = fpcu_pkg::CMD_DIV_INIT;
                        end
                    end
                    fpcu_pkg::FUNC_POW: begin
                        if (i_stat.a_zero) begin
                            o_ctrl.cmd = fpcu_pkg::CMD_ZERO;
                        end else if (i_stat.nb || i_stat.b_zero) begin
                            o_ctrl.cmd = fpcu_pkg::CMD_ONE;
                        end else begin
                            o_ctrl.cmd = fpcu_pkg::CMD_POW_INIT;
                        end
                    end
                    fpcu_pkg::FUNC_ROOT: begin
                        if (i_stat.na) begin
                            o_ctrl.cmd = fpcu_pkg::CMD_ERR;
                            o_ctrl.err = fpcu_pkg::STAT_NEG_ROOT;
                        end else if (i_stat.a_zero) begin
                            o_ctrl.cmd = fpcu_pkg::CMD_ZERO;
                        end else begin
                            o_ctrl.cmd = fpcu_pkg::CMD_ROOT_INIT;
                        end
                    end
                    default: begin
                        o_ctrl.cmd = fpcu_pkg::CMD_ERR;
                        o_ctrl.err = fpcu_pkg::STAT_INVALID;
                    end
                endcase
            end
            fpcu_pkg::S_MUL_PACK:  o_ctrl.cmd = fpcu_pkg::CMD_MUL_PACK;
            fpcu_pkg::S_DIV_STEP:  o_ctrl.cmd = fpcu_pkg::CMD_DIV_STEP;
            fpcu_pkg::S_DIV_PACK:  o_ctrl.cmd = fpcu_pkg::CMD_DIV_PACK;
            fpcu_pkg::S_POW_MUL:   o_ctrl.cmd = fpcu_pkg::CMD_POW_MUL;
            fpcu_pkg::S_POW_UPD:   o_ctrl.cmd = fpcu_pkg::CMD_POW_UPD;
            fpcu_pkg::S_POW_PACK:  o_ctrl.cmd = fpcu_pkg::CMD_POW_PACK;
            fpcu_pkg::S_ROOT_LEN:  o_ctrl.cmd = fpcu_pkg::CMD_ROOT_LEN;
            fpcu_pkg::S_ROOT_NORM: o_ctrl.cmd = fpcu_pkg::CMD_ROOT_NORM;
            fpcu_pkg::S_ROOT_M1:   o_ctrl.cmd = fpcu_pkg::CMD_ROOT_M1;
            fpcu_pkg::S_ROOT_M2:   o_ctrl.cmd = fpcu_pkg::CMD_ROOT_M2;
            fpcu_pkg::S_ROOT_M3:   o_ctrl.cmd = fpcu_pkg::CMD_ROOT_M3;
            fpcu_pkg::S_ROOT_B:    o_ctrl.cmd = fpcu_pkg::CMD_ROOT_B;
            fpcu_pkg::S_ROOT_PACK: o_ctrl.cmd = fpcu_pkg::CMD_ROOT_PACK;
            default:               o_ctrl.cmd = fpcu_pkg::CMD_NOP;
        endcase
    end

endmodule

[design/fpcu_datapath.sv]
// Datapath of the calculator: operand registers, shared multiplier, divider and root state.
module fpcu_datapath (
    input  logic                i_clk,
    input  fpcu_pkg::t_fpcu_in  i_in,
    input  fpcu_pkg::t_ctrl     i_ctrl,
    output fpcu_pkg::t_stat     o_stat,
    output fpcu_pkg::t_fpcu_out o_out
);

    localparam logic signed [33:0] QONE  = 34'sd1073741824;
    localparam logic signed [33:0] QTHREE = 34'sd3221225472;
    localparam logic [47:0] LIM_POS = 48'h0000_7FFF_FFFF;
    localparam logic [47:0] LIM_NEG = 48'h0000_8000_0000;
    localparam logic [31:0] ONE_Q   = 32'h0001_0000;

    // Result is {saturated, value}; the magnitude is clamped to the signed range.
    function automatic logic [32:0] pack(input logic neg, input logic ovf,
                                         input logic [47:0] mag);
        logic sat;
        logic [31:0] val;
        sat = ovf || (mag > (neg ? LIM_NEG : LIM_POS));
        if (sat) begin
            val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            val = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
        end
        return {sat, val};
    endfunction

    logic [2:0]         r_func;
    logic               r_na;
    logic               r_nb;
    logic [31:0]        r_ma;
    logic [31:0]        r_mb;
    logic signed [67:0] r_prod;
    logic [31:0]        r_res;
    logic [2:0]         r_stat;
    logic [15:0]        r_cnt;
    logic [15:0]        r_n;
    logic [47:0]        r_dvd;
    logic [31:0]        r_rem;
    logic [47:0]        r_quo;
    logic [31:0]        r_m;
    logic               r_neg;
    logic               r_povf;
    logic [31:0]        r_t;
    logic [5:0]         r_len;
    logic [4:0]         r_fsh;
    logic signed [33:0] r_a;
    logic signed [33:0] r_b;

    logic [31:0]        va;
    logic [31:0]        vb;
    logic               na;
    logic               nb;
    logic signed [33:0] m_a;
    logic signed [33:0] m_b;
    logic signed [67:0] prod;
    logic               nbe;
    logic [32:0]        sum;
    logic [32:0]        pk_add;
    logic [32:0]        rem_sh;
    logic [47:0]        pow_lo;
    logic               pow_ovf;
    logic               pow_brk;
    logic               pow_last;
    logic signed [6:0]  d;
    logic signed [6:0]  k;
    logic signed [6:0]  sh;
    logic signed [6:0]  fsh;
    logic [31:0]        y;
    logic [32:0]        root_r;
    logic [32:0]        pk;
    logic signed [33:0] b_new;

    assign va = i_in.operand_a;
    assign vb = i_in.operand_b;
    assign na = va[31];
    assign nb = vb[31];

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_ctrl.cmd)
            fpcu_pkg::CMD_MUL: begin
                m_a = {2'b00, r_ma};
                m_b = {2'b00, r_mb};
            end
            fpcu_pkg::CMD_POW_MUL: begin
                m_a = {2'b00, r_m};
                m_b = {2'b00, r_ma};
            end
            fpcu_pkg::CMD_ROOT_M1: begin
                m_a = r_a;
                m_b = QONE + (r_b >>> 1);
            end
            fpcu_pkg::CMD_ROOT_M2: begin
                m_a = QTHREE + r_b;
                m_b = r_b;
            end
            fpcu_pkg::CMD_ROOT_M3: begin
                m_a = $signed(r_prod[63:30]);
                m_b = r_b;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign prod = m_a * m_b;

    // Add and subtract work on sign and magnitude.
    always_comb begin
        nbe = r_nb ^ (r_func == fpcu_pkg::FUNC_SUB);
        sum = {1'b0, r_ma} + {1'b0, r_mb};
        if (r_na == nbe) begin
            pk_add = pack(r_na, 1'b0, {15'b0, sum});
        end else if (r_ma >= r_mb) begin
            pk_add = pack(r_na && (r_ma != r_mb), 1'b0, {16'b0, r_ma - r_mb});
        end else begin
            pk_add = pack(nbe, 1'b0, {16'b0, r_mb - r_ma});
        end
    end

    assign rem_sh = {r_rem, r_dvd[47]};

    assign pow_lo   = r_prod[63:16];
    assign pow_ovf  = pow_lo > LIM_NEG;
    assign pow_brk  = (pow_lo == {16'b0, r_m}) || (pow_lo == 48'd0);
    assign pow_last = (r_cnt + 16'd1) == r_n;

    // Normalization: radicand lands in [0.5, 2) as Q2.30 times 4**k.
    always_comb begin
        d   = $signed({1'b0, r_len}) - 7'sd16;
        k   = d >>> 1;
        sh  = 7'sd14 - (k <<< 1);
        fsh = 7'sd14 - k;
        y   = r_ma << sh[4:0];
    end

    assign root_r = r_a[32:0] >> r_fsh;
    assign b_new  = $signed(r_prod[65:32]);

    always_comb begin
        case (i_ctrl.cmd)
            fpcu_pkg::CMD_MUL_PACK:  pk = pack(r_na != r_nb, 1'b0, r_prod[63:16]);
            fpcu_pkg::CMD_DIV_PACK:  pk = pack(r_na != r_nb, 1'b0, r_quo);
            fpcu_pkg::CMD_POW_PACK:  pk = pack(r_neg, r_povf, {16'b0, r_m});
            fpcu_pkg::CMD_ROOT_PACK: pk = pack(1'b0, r_a[33], {15'b0, root_r});
            default:                 pk = pk_add;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            fpcu_pkg::CMD_LOAD: begin
                r_func <= i_in.func;
                r_na   <= na;
                r_nb   <= nb;
                r_ma   <= na ? (~va + 32'd1) : va;
                r_mb   <= nb ? (~vb + 32'd1) : vb;
            end
            fpcu_pkg::CMD_ADD, fpcu_pkg::CMD_MUL_PACK, fpcu_pkg::CMD_DIV_PACK,
            fpcu_pkg::CMD_POW_PACK, fpcu_pkg::CMD_ROOT_PACK: begin
                r_res  <= pk[31:0];
                r_stat <= pk[32] ? fpcu_pkg::STAT_SAT : fpcu_pkg::STAT_OK;
            end
            fpcu_pkg::CMD_MUL, fpcu_pkg::CMD_POW_MUL, fpcu_pkg::CMD_ROOT_M1: begin
                r_prod <= prod;
            end
            fpcu_pkg::CMD_DIV_INIT: begin
                r_dvd <= {r_ma, 16'b0};
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            fpcu_pkg::CMD_DIV_STEP: begin
                r_dvd <= {r_dvd[46:0], 1'b0};
                r_cnt <= r_cnt + 16'd1;
                if (rem_sh >= {1'b0, r_mb}) begin
                    r_rem <= 32'(rem_sh - {1'b0, r_mb});
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_quo <= {r_quo[46:0], 1'b0};
                end
            end
            fpcu_pkg::CMD_POW_INIT: begin
                r_m    <= ONE_Q;
                r_cnt  <= '0;
                r_n    <= 16'(({1'b0, r_mb} + 33'h0_0000_FFFF) >> fpcu_pkg::FRAC_W);
                // The step count is odd when the integer part is odd and the
                // fraction is zero, or the integer part is even and the fraction is not.
                r_neg  <= r_na && (r_mb[fpcu_pkg::FRAC_W] ^
                                   (r_mb[fpcu_pkg::FRAC_W-1:0] != '0));
                r_povf <= 1'b0;
            end
            fpcu_pkg::CMD_POW_UPD: begin
                r_cnt <= r_cnt + 16'd1;
                if (pow_ovf) begin
                    r_povf <= 1'b1;
                end else begin
                    r_m <= pow_lo[31:0];
                end
            end
            fpcu_pkg::CMD_ROOT_INIT: begin
                r_t   <= r_ma;
                r_len <= '0;
            end
            fpcu_pkg::CMD_ROOT_LEN: begin
                if (r_t != '0) begin
                    r_t   <= r_t >> 1;
                    r_len <= r_len + 6'd1;
                end
            end
            fpcu_pkg::CMD_ROOT_NORM: begin
                r_a   <= {2'b00, y};
                r_b   <= QONE - {2'b00, y};
                r_fsh <= fsh[4:0];
                r_cnt <= '0;
            end
            fpcu_pkg::CMD_ROOT_M2: begin
                r_a    <= $signed(r_prod[63:30]);
                r_prod <= prod;
            end
            fpcu_pkg::CMD_ROOT_M3: begin
                r_prod <= prod;
            end
            fpcu_pkg::CMD_ROOT_B: begin
                r_b   <= b_new;
                r_cnt <= r_cnt + 16'd1;
            end
            fpcu_pkg::CMD_ZERO: begin
                r_res  <= '0;
                r_stat <= fpcu_pkg::STAT_OK;
            end
            fpcu_pkg::CMD_ONE: begin
                r_res  <= ONE_Q;
                r_stat <= fpcu_pkg::STAT_OK;
            end
            fpcu_pkg::CMD_ERR: begin
                r_res  <= '0;
                r_stat <= i_ctrl.err;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_stat.func      = r_func;
    assign o_stat.na        = r_na;
    assign o_stat.nb        = r_nb;
    assign o_stat.a_zero    = (r_ma == '0);
    assign o_stat.b_zero    = (r_mb == '0);
    assign o_stat.div_last  = (r_cnt == 16'd47);
    assign o_stat.pow_stop  = pow_ovf || pow_brk || pow_last;
    assign o_stat.len_done  = (r_t == '0);
    assign o_stat.root_stop = (b_new == '0) ||
                              (r_cnt == 16'(fpcu_pkg::ROOT_ITER - 1));

    assign o_out.result = r_res;
    assign o_out.status = r_stat;

endmodule

[design/fixed_point_calculator_unit_top.sv]
// Top level of the fixed-point calculator unit: controller plus datapath.
//
// Usage: drive i_in (operation code and two signed Q16.16 operands) and raise
// start; the transaction is taken at a clock edge where start is high and busy
// is low. busy stays high until the result has been shown. Each transaction
// returns exactly one result: o_out (result and status) is valid for one
// cycle, marked by o_valid, and must be taken in that cycle; the receiver
// cannot stall the block.
// Sequencing: add, subtract, error and trivial cases finish right after
// dispatch; multiply forms the product, then packs it; divide forms one
// quotient bit per cycle over 48 bits, then packs; power repeats a multiply
// and an update step, the step count being up to ceil(b) and ending early
// once the running value overflows, reaches zero or stops changing; square
// root runs a leading-one search, then at most 8 refinement passes through
// states M1, M2, M3 and B, then packs. All products go through one shared
// multiplier, which sets the iteration costs. One transaction is in flight
// at a time; a new one may start the cycle after o_valid. Synchronous
// active-low reset returns the controller to idle, dropping busy and o_valid.
module fixed_point_calculator_unit_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  fpcu_pkg::t_fpcu_in  i_in,
    output logic                busy,
    output logic                o_valid,
    output fpcu_pkg::t_fpcu_out o_out
);

    fpcu_pkg::t_ctrl ctrl;
    fpcu_pkg::t_stat stat;

    fpcu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    fpcu_datapath u_datapath (
        .i_clk  (i_clk),
        .i_in   (i_in),
        .i_ctrl (ctrl),
        .o_stat (stat),
        .o_out  (o_out)
    );

`ifndef ASSERT_OFF
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted transaction did not make the block busy");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.status == fpcu_pkg::STAT_DIV0 ||
                     o_out.status == fpcu_pkg::STAT_NEG_ROOT ||
                     o_out.status == fpcu_pkg::STAT_INVALID)) |-> (o_out.result == '0))
        else $error("error result carries a nonzero value");
`endif

endmodule

[tb/sv/fpcu_result_checker.sv]
// Checker for the fixed-point calculator unit: predicts each result and compares it.
module fpcu_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  fpcu_pkg::t_fpcu_in  i_in,
    input  logic                o_valid,
    input  fpcu_pkg::t_fpcu_out o_out,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam longint QONE = 64'sd1 << 30;

    fpcu_pkg::t_fpcu_out expected_q[$];
    int                  mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_q.size();

    // Saturating conversion of a sign and magnitude to the 32-bit result.
    function automatic logic [31:0] fit_q16(input bit neg, input logic [127:0] mag,
                                            inout logic [2:0] st);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (mag > lim) begin
            st = fpcu_pkg::STAT_SAT;
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return neg ? 32'(-mag[31:0]) : mag[31:0];
    endfunction

    function automatic logic [31:0] power_q16(input bit na, input logic [63:0] ma,
                                              input bit nb, input logic [63:0] mb,
                                              inout logic [2:0] st);
        logic [63:0]  steps;
        logic [127:0] m;
        logic [127:0] prod;
        bit           neg;
        if (ma == 0)
            return 32'd0;
        if (nb || mb == 0)
            return fit_q16(1'b0, 128'h1_0000, st);
        steps = (mb + 64'hffff) >> 16;
        neg   = na && steps[0];
        m     = 128'h1_0000;
        for (longint i = 0; i < steps; i++) begin
            prod = (m * ma) >> 16;
            if (prod > 128'h8000_0000)
                return fit_q16(neg, 128'hffff_ffff_ffff, st);
            if (prod == m || prod == 0) begin
                m = prod;
                break;
            end
            m = prod;
        end
        return fit_q16(neg, m, st);
    endfunction

    function automatic logic [31:0] root_q16(input logic [63:0] x, inout logic [2:0] st);
        int          len;
        int          d;
        int          k;
        int          sh;
        int          passes;
        longint      a_est;
        longint      b_err;
        longint      p;
        logic [63:0] y;
        logic [63:0] r;
        if (x == 0)
            return 32'd0;
        len = 0;
        for (logic [63:0] t = x; t != 0; t = t >> 1)
            len++;
        d  = len - fpcu_pkg::FRAC_W;
        k  = (d >= 0) ? d / 2 : -((1 - d) / 2);
        sh = 30 - fpcu_pkg::FRAC_W - 2 * k;
        y  = (sh >= 0) ? (x << sh) : (x >> (-sh));
        a_est  = longint'(y);
        b_err  = QONE - longint'(y);
        passes = 0;
        do begin
            a_est = (a_est * (QONE + (b_err >>> 1))) >>> 30;
            p     = ((3 * QONE + b_err) * b_err) >>> 30;
            b_err = (p * b_err) >>> 32;
            passes++;
        end while (b_err != 0 && passes < fpcu_pkg::ROOT_ITER);
        sh = k + fpcu_pkg::FRAC_W - 30;
        r  = (sh >= 0) ? (64'(a_est) << sh) : (64'(a_est) >> (-sh));
        return fit_q16(1'b0, {64'd0, r}, st);
    endfunction

    function automatic fpcu_pkg::t_fpcu_out predict_result(input fpcu_pkg::t_fpcu_in x);
        fpcu_pkg::t_fpcu_out res;
        bit                  na;
        bit                  nb;
        logic [63:0]         ma;
        logic [63:0]         mb;
        longint              sum;
        logic [2:0]          st;
        na  = x.operand_a[31];
        nb  = x.operand_b[31];
        ma  = na ? 64'(-longint'(x.operand_a)) : 64'(x.operand_a);
        mb  = nb ? 64'(-longint'(x.operand_b)) : 64'(x.operand_b);
        st  = fpcu_pkg::STAT_OK;
        res.result = '0;
        case (x.func)
            fpcu_pkg::FUNC_ADD, fpcu_pkg::FUNC_SUB: begin
                sum = (x.func == fpcu_pkg::FUNC_ADD)
                    ? longint'(x.operand_a) + longint'(x.operand_b)
                    : longint'(x.operand_a) - longint'(x.operand_b);
                res.result = fit_q16(sum < 0, 128'(sum < 0 ? -sum : sum), st);
            end
            fpcu_pkg::FUNC_MUL: res.result = fit_q16(na != nb, 128'((ma * mb) >> 16), st);
            fpcu_pkg::FUNC_DIV: begin
                if (mb == 0)
                    st = fpcu_pkg::STAT_DIV0;
                else
                    res.result = fit_q16(na != nb, 128'((ma << 16) / mb), st);
            end
            fpcu_pkg::FUNC_POW: res.result = power_q16(na, ma, nb, mb, st);
            fpcu_pkg::FUNC_ROOT: begin
                if (na)
                    st = fpcu_pkg::STAT_NEG_ROOT;
                else
                    res.result = root_q16(ma, st);
            end
            default: st = fpcu_pkg::STAT_INVALID;
        endcase
        res.status = st;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Results are handled before new transactions so that the queue order holds.
    always @(posedge i_clk) begin
        fpcu_pkg::t_fpcu_out want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h status %0d",
                                          o_out.result, o_out.status));
            end else begin
                want = expected_q.pop_front();
                if (o_out.result !== want.result)
                    report_mismatch($sformatf("result %h, expected %h",
                                              o_out.result, want.result));
                if (o_out.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_out.status, want.status));
            end
        end
        if (i_rst_n && start && !busy)
            expected_q.push_back(predict_result(i_in));
    end

endmodule

[tb/sv/fixed_point_calculator_unit_top_test.sv]
// Stimulus and verdict for the fixed-point calculator unit testbench.
module fixed_point_calculator_unit_top_test;

    localparam int  RANDOM_ITEMS = 1400;
    localparam int  DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    fpcu_pkg::t_fpcu_in  i_in = '0;
    logic                busy;
    logic                o_valid;
    fpcu_pkg::t_fpcu_out o_out;
    int                  fail_count;
    int                  pending;
    longint              cycles = 0;
    int                  func_seen[8];
    bit                  idling_on = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    fixed_point_calculator_unit_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_in   (i_in),
        .busy   (busy),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    fpcu_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drives one transaction from a falling edge and returns at the falling
    // edge after the rising edge that accepted it.
    task automatic issue_op(input logic [2:0] func, input logic [31:0] a,
                            input logic [31:0] b);
        if (idling_on && $urandom_range(0, 99) < 16) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start     = 1'b1;
        i_in.func = func;
        i_in.operand_a = a;
        i_in.operand_b = b;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        func_seen[func]++;
    endtask

    function automatic logic [31:0] random_operand();
        return $urandom >> $urandom_range(0, 31) ^ ($urandom_range(0, 1) ? 32'hffff_ffff : 0);
    endfunction

    initial begin
        logic [2:0]  f;
        logic [31:0] a;
        logic [31:0] b;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        issue_op(fpcu_pkg::FUNC_ADD, 32'h7fff_ffff, 32'h0000_0001);
        issue_op(fpcu_pkg::FUNC_ADD, 32'h8000_0000, 32'hffff_ffff);
        issue_op(fpcu_pkg::FUNC_SUB, 32'h8000_0000, 32'h0000_0001);
        issue_op(fpcu_pkg::FUNC_SUB, 32'h1234_5678, 32'h1234_5678);
        issue_op(fpcu_pkg::FUNC_MUL, 32'h8000_0000, 32'h8000_0000);
        issue_op(fpcu_pkg::FUNC_MUL, 32'hffff_0000, 32'h0000_8000);
        issue_op(fpcu_pkg::FUNC_DIV, 32'h0001_0000, 32'h0000_0000);
        issue_op(fpcu_pkg::FUNC_DIV, 32'h0000_0000, 32'h0000_0000);
        issue_op(fpcu_pkg::FUNC_DIV, 32'h7fff_ffff, 32'h0000_0001);
        issue_op(fpcu_pkg::FUNC_DIV, 32'h8000_0000, 32'h7fff_ffff);
        issue_op(fpcu_pkg::FUNC_POW, 32'h0000_0000, 32'hfffe_0000);
        issue_op(fpcu_pkg::FUNC_POW, 32'hfffd_0000, 32'h0000_0000);
        issue_op(fpcu_pkg::FUNC_POW, 32'hfffe_0000, 32'h0002_8000);
        issue_op(fpcu_pkg::FUNC_POW, 32'h0002_0000, 32'h0040_0000);
        issue_op(fpcu_pkg::FUNC_POW, 32'h0000_ffff, 32'h7fff_ffff);
        issue_op(fpcu_pkg::FUNC_POW, 32'h0001_0000, 32'h7fff_ffff);
        issue_op(fpcu_pkg::FUNC_POW, 32'h8000_0000, 32'h8000_0000);
        issue_op(fpcu_pkg::FUNC_ROOT, 32'h0000_0000, 32'h0);
        issue_op(fpcu_pkg::FUNC_ROOT, 32'h0000_0001, 32'h0);
        issue_op(fpcu_pkg::FUNC_ROOT, 32'h0001_0000, 32'h0);
        issue_op(fpcu_pkg::FUNC_ROOT, 32'h7fff_ffff, 32'hffff_ffff);
        issue_op(fpcu_pkg::FUNC_ROOT, 32'hffff_ffff, 32'h0);
        issue_op(3'd6, 32'hffff_ffff, 32'hffff_ffff);
        issue_op(3'd7, 32'h0, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling_on = !(n >= 500 && n < 750);
            f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
            a = random_operand();
            b = random_operand();
            // Keep most exponents at or below 37 so those power runs stay a few dozen steps.
            if (f == fpcu_pkg::FUNC_POW && $urandom_range(0, 99) != 0)
                b = 32'($urandom_range(0, 40 << 16)) - 32'h0003_0000;
            issue_op(f, a, b);
        end
        start = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d add, %0d sub, %0d mul, %0d div, %0d pow, %0d root, %0d invalid",
                 func_seen[0], func_seen[1], func_seen[2], func_seen[3], func_seen[4],
                 func_seen[5], func_seen[6] + func_seen[7]);
        $display("with random start gaps, %0d mismatches", fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/fpcu_pkg.sv
design/fpcu_ctrl.sv
design/fpcu_datapath.sv
design/fixed_point_calculator_unit_top.sv
tb/sv/fpcu_result_checker.sv
tb/sv/fixed_point_calculator_unit_top_test.sv
